[src/bol_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants for the bounded ordered list
// Opcodes, status codes, sizes and the control struct broadcast to the cells.
// ----------------------------------------------------------------------------
package bol_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [1:0] OP_REMOVE     = 2'd2;
   localparam logic [1:0] OP_READ       = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic              apply;
      logic [1:0]        op;
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] value;
      logic [IDX_W-1:0]  rd_addr;
   } bol_ctrl_type;

endpackage
`default_nettype wire

[src/bounded_ordered_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_list: ordered list of signed 32-bit values in a cell chain
// Push front, push back, remove first match and read by position.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                                   tuser
//  req       in         value, position                         opcode
//  rsp       out        read, total, front, back, empty         status
//
// An item goes through accept, execute in the cell chain, then a
// second pass over the shared read chain to pick up the new back entry.
// Synchronous reset empties the list; entries themselves are not cleared.
// A stalled rsp holds the result register and keeps the item in the last
// step; req_tready stays low until the result register frees up.
// ----------------------------------------------------------------------------
module bounded_ordered_list
   import bol_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_tvalid,
   output logic          req_tready,
   input  wire  [39:0]   req_tdata,  // value[31:0], position[35:32], zero pad
   input  wire  [1:0]    req_tuser,  // opcode[1:0]
   output logic          rsp_tvalid,
   input  wire           rsp_tready,
   output logic [103:0]  rsp_tdata,  // read_value[31:0], element_total[36:32],
                                     // front_value[68:37], back_value[100:69],
                                     // is_empty[101], zero pad
   output logic [2:0]    rsp_tuser   // status[2:0]
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        op_ff;
   logic [DATA_W-1:0] value_ff;
   logic [3:0]        pos_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        st_ff, st_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [103:0]      rsp_data_ff;
   logic [2:0]        rsp_user_ff;

   bol_ctrl_type      ctrl;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic              found_chain [CAPACITY+1];
   logic [DATA_W-1:0] rd_chain [CAPACITY+1];
   logic              full;
   logic              is_push;
   logic              found;
   logic              out_free;
   logic              empty;
   logic [DATA_W-1:0] front_val, back_val;

   assign full     = count_ff == CNT_W'(CAPACITY);
   assign is_push  = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK);
   assign found    = found_chain[CAPACITY];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign empty    = count_ff == '0;

   // a remove with no match leaves every cell in place on its own
   always_comb begin
      ctrl.op      = op_ff;
      ctrl.count   = count_ff;
      ctrl.value   = value_ff;
      ctrl.apply   = (state_ff == S_EXEC) &&
                     ((is_push && !full) || (op_ff == OP_REMOVE));
      ctrl.rd_addr = (state_ff == S_EXEC) ? IDX_W'(pos_ff)
                                          : IDX_W'(count_ff - 1'b1);
   end

   assign found_chain[0] = 1'b0;
   assign rd_chain[0]    = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_d, next_d;
      if (i == 0) begin : g_head
         assign prev_d = value_ff;
      end else begin : g_mid
         assign prev_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_d = cell_data[i];
      end else begin : g_body
         assign next_d = cell_data[i+1];
      end
      bol_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .prev_data  (prev_d),
         .next_data  (next_d),
         .found_in   (found_chain[i]),
         .rd_in      (rd_chain[i]),
         .data_out   (cell_data[i]),
         .found_out  (found_chain[i+1]),
         .rd_out     (rd_chain[i+1])
      );
   end

   // execute step: status, read data and new count
   always_comb begin
      st_in    = ST_OK;
      rd_in    = '0;
      count_in = count_ff;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) st_in = ST_FULL;
            else count_in = count_ff + 1'b1;
         end
         OP_REMOVE: begin
            if (!found) st_in = ST_NOTFOUND;
            else count_in = count_ff - 1'b1;
         end
         OP_READ: begin
            if (empty) st_in = ST_EMPTY;
            else if ({28'd0, pos_ff} >= 32'(count_ff)) st_in = ST_RANGE;
            else rd_in = rd_chain[CAPACITY];
         end
         default: st_in = ST_OK;
      endcase
   end

   assign front_val = empty ? '0 : cell_data[0];
   assign back_val  = empty ? '0 : rd_chain[CAPACITY];

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_EXEC;
         S_EXEC: state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff    <= req_tuser;
         value_ff <= req_tdata[31:0];
         pos_ff   <= req_tdata[35:32];
      end
      if (state_ff == S_EXEC) begin
         st_ff <= st_in;
         rd_ff <= rd_in;
      end
      if (state_ff == S_FIN && out_free) begin
         rsp_user_ff <= st_ff;
         rsp_data_ff <= {2'b00, empty, back_val, front_val, 5'(count_ff), rd_ff};
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

[src/bol_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bol_cell: one list slot
// Holds one entry, compares it against the broadcast value, shifts toward
// either neighbor and drives the shared read chain when addressed.
// ----------------------------------------------------------------------------
module bol_cell
   import bol_pkg::*;
(
   input  wire                clock,
   input  wire bol_ctrl_type  ctrl,
   input  wire  [IDX_W-1:0]   cell_index,
   input  wire  [DATA_W-1:0]  prev_data,
   input  wire  [DATA_W-1:0]  next_data,
   input  wire                found_in,
   input  wire  [DATA_W-1:0]  rd_in,
   output logic [DATA_W-1:0]  data_out,
   output logic               found_out,
   output logic [DATA_W-1:0]  rd_out
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              occupied;
   logic              at_tail;

   assign occupied  = CNT_W'(cell_index) < ctrl.count;
   assign at_tail   = CNT_W'(cell_index) == ctrl.count;
   // set at and beyond the first matching slot
   assign found_out = found_in | (occupied & (data_ff == ctrl.value));
   assign rd_out    = rd_in | ((cell_index == ctrl.rd_addr) ? data_ff : '0);
   assign data_out  = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.apply) begin
         case (ctrl.op)
            OP_PUSH_FRONT: data_in = prev_data;
            OP_PUSH_BACK:  if (at_tail) data_in = ctrl.value;
            OP_REMOVE:     if (found_out) data_in = next_data;
            default:       data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

[src/bol_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bol_checker: port-level checks for the bounded ordered list
// Result consistency and rsp channel behavior under backpressure.
// ----------------------------------------------------------------------------
module bol_checker
   import bol_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          rsp_tvalid,
   input wire          rsp_tready,
   input wire  [103:0] rsp_tdata,
   input wire  [2:0]   rsp_tuser
);

   // empty flag agrees with the entry count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[101] == (rsp_tdata[36:32] == 5'd0)))
      else $error("is_empty disagrees with element_total");

   // an empty list reports zero front and back
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[101]) |-> (rsp_tdata[68:37] == '0 && rsp_tdata[100:69] == '0))
      else $error("empty list with nonzero front or back");

   // failed operations return zero read data
   a_fail_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata[31:0] == '0))
      else $error("read data on a failed operation");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp transfer dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("rsp payload changed while stalled");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for bounded_ordered_list
// Streams push/remove/read requests into the list and checks every response
// against an in-bench shadow list. A directed burst covers empty, full,
// out-of-range and no-match cases. Random traffic then swings between fill
// and drain so the list keeps reaching both ends, under three idle mixes and
// one long response stall.
// ----------------------------------------------------------------------------
module tb;
   import bol_pkg::*;

   localparam int          STALL_LIMIT = 2000;
   localparam int          HOLD_CYCLES = 120;
   localparam int          TAIL_CYCLES = 20;
   localparam logic [31:0] V_MIN       = 32'h8000_0000;
   localparam logic [31:0] V_MAX       = 32'h7fff_ffff;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] value;
      logic [3:0]  position;
   } list_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] read_value;
      logic [4:0]  element_total;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic        is_empty;
   } list_rsp_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [39:0]   req_tdata   = '0;
   logic [1:0]    req_tuser   = '0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;

   list_req_type  pending_reqs[$];
   list_rsp_type  expected_rsps[$];

   // shadow copy of the list contents
   logic [31:0]   shadow_list[CAPACITY];
   int            shadow_len  = 0;

   int            send_idle_pct = 36;
   int            recv_idle_pct = 54;
   logic          hold_rsp      = 1'b0;
   int unsigned   hold_at       = 0;
   int unsigned   req_total     = 0;
   int unsigned   err_count     = 0;
   int unsigned   quiet_cycles  = 0;

   bounded_ordered_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // apply one operation to the shadow list and queue the response it gives
   task automatic apply_list_op(input logic [1:0] op, input logic [31:0] value,
                                input logic [3:0] position);
      list_rsp_type r;
      int           hit;
      r = '{status: ST_OK, read_value: '0, element_total: '0,
            front_value: '0, back_value: '0, is_empty: 1'b0};
      hit = -1;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = value;
               shadow_len++;
            end else begin
               shadow_list[shadow_len] = value;
               shadow_len++;
            end
         end
         OP_REMOVE: begin
            for (int i = 0; i < shadow_len; i++)
               if (hit < 0 && shadow_list[i] == value) hit = i;
            if (hit < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               for (int i = hit; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
               shadow_len--;
            end
         end
         default: begin
            if (shadow_len == 0)
               r.status = ST_EMPTY;
            else if (int'(position) >= shadow_len)
               r.status = ST_RANGE;
            else
               r.read_value = shadow_list[position];
         end
      endcase
      r.element_total = shadow_len[4:0];
      if (shadow_len == 0) begin
         r.is_empty = 1'b1;
      end else begin
         r.front_value = shadow_list[0];
         r.back_value  = shadow_list[shadow_len-1];
      end
      expected_rsps.push_back(r);
   endtask

   task automatic add_req(input logic [1:0] op, input logic [31:0] value,
                          input logic [3:0] position);
      list_req_type q;
      q.op       = op;
      q.value    = value;
      q.position = position;
      pending_reqs.push_back(q);
   endtask

   // mostly a small pool so removes find matches, sometimes any 32-bit value
   function automatic logic [31:0] pick_value();
      logic [31:0] pool[6];
      pool = '{V_MIN, V_MAX, 32'h0, 32'hffff_ffff, 32'h1, 32'h5a5a_a5a5};
      if ($urandom_range(99) < 70)
         return pool[$urandom_range(5)];
      return $urandom;
   endfunction

   // random traffic that alternates between filling and draining the list
   task automatic add_random_reqs(input int count);
      bit          filling;
      int          run_left;
      int unsigned roll;
      logic [1:0]  push_op;
      filling  = 1'b1;
      run_left = $urandom_range(20, 60);
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            filling  = !filling;
            run_left = $urandom_range(20, 60);
         end
         run_left--;
         roll    = $urandom_range(99);
         push_op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         if (roll < (filling ? 70 : 12))
            add_req(push_op, pick_value(), 4'($urandom_range(15)));
         else if (roll < 85)
            add_req(OP_REMOVE, pick_value(), 4'($urandom_range(15)));
         else
            add_req(OP_READ, $urandom, 4'($urandom_range(15)));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      list_req_type q;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_list_op(req_tuser, req_tdata[31:0], req_tdata[35:32]);
            req_total <= req_total + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               q = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, q.position, q.value};
               req_tuser  <= q.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      list_rsp_type e;
      list_rsp_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status        = rsp_tuser;
            got.read_value    = rsp_tdata[31:0];
            got.element_total = rsp_tdata[36:32];
            got.front_value   = rsp_tdata[68:37];
            got.back_value    = rsp_tdata[100:69];
            got.is_empty      = rsp_tdata[101];
            if (expected_rsps.size() == 0) begin
               err_count <= err_count + 1;
               if (err_count < 10)
                  $display("ERROR: response with none expected: status=%0d total=%0d",
                           got.status, got.element_total);
            end else begin
               e = expected_rsps.pop_front();
               if (got.status !== e.status || got.read_value !== e.read_value ||
                   got.element_total !== e.element_total ||
                   got.front_value !== e.front_value ||
                   got.back_value !== e.back_value || got.is_empty !== e.is_empty) begin
                  err_count <= err_count + 1;
                  if (err_count < 10) begin
                     $display("ERROR: response mismatch");
                     $display("  expected status=%0d read=%h total=%0d front=%h back=%h empty=%b",
                              e.status, e.read_value, e.element_total,
                              e.front_value, e.back_value, e.is_empty);
                     $display("  actual   status=%0d read=%h total=%0d front=%h back=%h empty=%b",
                              got.status, got.read_value, got.element_total,
                              got.front_value, got.back_value, got.is_empty);
                  end
               end
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long response stall while requests keep coming, so the input backs up
   initial begin
      wait (hold_at != 0 && req_total >= hold_at);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, no match, range, full, duplicates
      add_req(OP_READ, 32'h0, 4'd0);
      add_req(OP_REMOVE, V_MIN, 4'd0);
      add_req(OP_PUSH_FRONT, V_MIN, 4'd15);
      add_req(OP_PUSH_BACK, V_MAX, 4'd0);
      add_req(OP_READ, 32'hffff_ffff, 4'd1);
      add_req(OP_READ, 32'h0, 4'd2);
      add_req(OP_REMOVE, 32'h1, 4'd0);
      add_req(OP_REMOVE, V_MIN, 4'd0);
      for (int i = 0; i < 15; i++)
         add_req((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                 (i % 3 == 0) ? V_MAX : $urandom, 4'(i));
      add_req(OP_PUSH_FRONT, 32'h0, 4'd0);
      add_req(OP_PUSH_BACK, 32'hffff_ffff, 4'd0);
      add_req(OP_READ, 32'h0, 4'd15);
      add_req(OP_REMOVE, V_MAX, 4'd0);
      add_random_reqs(400);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);

      send_idle_pct <= 54;
      recv_idle_pct <= 36;
      @(posedge clock);
      add_random_reqs(400);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);

      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_at       <= req_total + 150;
      @(posedge clock);
      add_random_reqs(400);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_rsps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
